// ===== rtl/core/ccd_pkg.sv =====
package ccd_pkg;

  // default width of the command age counter
  localparam int AGE_WIDTH_DEF = 16;

  // crc-16 ccitt-false
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // register reset values
  localparam logic [7:0]  FIRST_SYNC_RST      = 8'hA5;
  localparam logic [7:0]  SECOND_SYNC_RST     = 8'h5A;
  localparam logic [7:0]  EXPECTED_LENGTH_RST = 8'd8;
  localparam logic [15:0] TIMEOUT_MS_RST      = 16'd500;

  // configuration register indexes
  localparam logic [7:0] REG_FIRST_SYNC      = 8'd0;
  localparam logic [7:0] REG_SECOND_SYNC     = 8'd1;
  localparam logic [7:0] REG_EXPECTED_LENGTH = 8'd2;
  localparam logic [7:0] REG_TIMEOUT_MS      = 8'd3;

  // frame status codes
  localparam logic [1:0] STAT_NONE    = 2'd0;
  localparam logic [1:0] STAT_GOOD    = 2'd1;
  localparam logic [1:0] STAT_BAD_LEN = 2'd2;
  localparam logic [1:0] STAT_BAD_CRC = 2'd3;

  // item modes
  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  // last payload byte count (eight payload bytes per frame) and low crc byte count
  localparam logic [3:0] CNT_LAST_PAYLOAD = 4'd8;
  localparam logic [3:0] CNT_CRC_LOW      = 4'd9;

  typedef struct packed {
    logic       mode;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic        cmd_valid;
    logic [31:0] linear_bits;
    logic [31:0] angular_bits;
    logic [1:0]  frame_status;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  first_sync;
    logic [7:0]  second_sync;
    logic [7:0]  expected_length;
    logic [15:0] timeout_ms;
  } cfg_regs_t;

  // frame event from the deframer to the command holder
  typedef struct packed {
    logic        good;
    logic [31:0] linear;
    logic [31:0] angular;
  } frame_evt_t;

  // one byte through the crc, msb first
  function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) c = {c[14:0], 1'b0} ^ CRC_POLY;
      else       c = {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/ccd_deframer.sv =====
module ccd_deframer import ccd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       byte_en,
  input  logic [7:0] rx_byte,
  input  cfg_regs_t  cfg,
  output logic [1:0] status,
  output frame_evt_t frame_evt
);

  typedef enum logic [1:0] {PH_HUNT, PH_SYNC2, PH_FRAME} phase_t;

  phase_t      phase_r,       phase_nxt;
  logic [3:0]  byte_count_r,  byte_count_nxt;
  logic [15:0] crc_r,         crc_nxt;
  logic [7:0]  length_r,      length_nxt;
  logic [63:0] payload_r,     payload_nxt;
  logic [7:0]  crc_low_r,     crc_low_nxt;
  logic [15:0] crc_upd;
  logic [15:0] crc_start;
  logic [2:0]  lane;

  assign crc_upd   = crc_add(crc_r, rx_byte);
  assign crc_start = crc_add(CRC_INIT, rx_byte);
  assign lane      = byte_count_r[2:0] - 3'd1;

  // byte path next state
  always_comb begin
    phase_nxt      = phase_r;
    byte_count_nxt = byte_count_r;
    crc_nxt        = crc_r;
    length_nxt     = length_r;
    payload_nxt    = payload_r;
    crc_low_nxt    = crc_low_r;
    status         = STAT_NONE;
    frame_evt.good    = 1'b0;
    frame_evt.linear  = payload_r[31:0];
    frame_evt.angular = payload_r[63:32];
    if (byte_en) begin
      unique case (phase_r)
        PH_HUNT: begin
          if (rx_byte == cfg.first_sync) begin
            phase_nxt      = PH_SYNC2;
            byte_count_nxt = 4'd0;
            crc_nxt        = crc_start;
          end
        end
        PH_SYNC2: begin
          if (rx_byte == cfg.second_sync) begin
            phase_nxt      = PH_FRAME;
            byte_count_nxt = 4'd0;
            crc_nxt        = crc_upd;
          end else if (rx_byte == cfg.first_sync) begin
            // repeated first sync restarts the frame here
            phase_nxt      = PH_SYNC2;
            byte_count_nxt = 4'd0;
            crc_nxt        = crc_start;
          end else begin
            phase_nxt = PH_HUNT;
          end
        end
        PH_FRAME: begin
          if (byte_count_r == 4'd0) begin
            length_nxt     = rx_byte;
            payload_nxt    = '0;
            crc_nxt        = crc_upd;
            byte_count_nxt = 4'd1;
          end else if (byte_count_r <= CNT_LAST_PAYLOAD) begin
            for (int i = 0; i < 8; i++) begin
              if (lane == 3'(i)) payload_nxt[8*i +: 8] = rx_byte;
            end
            crc_nxt        = crc_upd;
            byte_count_nxt = byte_count_r + 4'd1;
          end else if (byte_count_r == CNT_CRC_LOW) begin
            crc_low_nxt    = rx_byte;
            byte_count_nxt = byte_count_r + 4'd1;
          end else begin
            // last crc byte: length check wins over crc check
            if (length_r != cfg.expected_length) begin
              status = STAT_BAD_LEN;
            end else if ({rx_byte, crc_low_r} != crc_r) begin
              status = STAT_BAD_CRC;
            end else begin
              status         = STAT_GOOD;
              frame_evt.good = 1'b1;
            end
            phase_nxt      = PH_HUNT;
            byte_count_nxt = 4'd0;
            crc_nxt        = CRC_INIT;
          end
        end
        default: begin
          phase_nxt = PH_HUNT;
        end
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HUNT;
      byte_count_r <= 4'd0;
      crc_r        <= CRC_INIT;
    end else begin
      phase_r      <= phase_nxt;
      byte_count_r <= byte_count_nxt;
      crc_r        <= crc_nxt;
    end
  end

  // frame capture registers
  always_ff @(posedge clk) begin
    length_r  <= length_nxt;
    payload_r <= payload_nxt;
    crc_low_r <= crc_low_nxt;
  end

endmodule

// ===== rtl/core/ccd_cmd_hold.sv =====
module ccd_cmd_hold import ccd_pkg::*; #(
  parameter int AGE_WIDTH = AGE_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        tick_en,
  input  frame_evt_t  frame_evt,
  input  logic [15:0] timeout_ms,
  output logic        cmd_valid,
  output logic [31:0] linear_bits,
  output logic [31:0] angular_bits
);

  localparam int CW = (AGE_WIDTH > 16) ? AGE_WIDTH : 16;

  logic                 valid_r,   valid_nxt;
  logic [31:0]          linear_r,  linear_nxt;
  logic [31:0]          angular_r, angular_nxt;
  logic [AGE_WIDTH-1:0] age_r,     age_nxt;
  logic [AGE_WIDTH-1:0] age_inc;

  // saturating age step
  assign age_inc = (age_r == {AGE_WIDTH{1'b1}}) ? age_r : age_r + 1'b1;

  always_comb begin
    valid_nxt   = valid_r;
    linear_nxt  = linear_r;
    angular_nxt = angular_r;
    age_nxt     = age_r;
    if (frame_evt.good) begin
      valid_nxt   = 1'b1;
      linear_nxt  = frame_evt.linear;
      angular_nxt = frame_evt.angular;
      age_nxt     = '0;
    end else if (tick_en && valid_r) begin
      age_nxt = age_inc;
      // timeout clears the command
      if (CW'(age_inc) > CW'(timeout_ms)) begin
        valid_nxt   = 1'b0;
        linear_nxt  = '0;
        angular_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= 1'b0;
      linear_r  <= '0;
      angular_r <= '0;
      age_r     <= '0;
    end else begin
      valid_r   <= valid_nxt;
      linear_r  <= linear_nxt;
      angular_r <= angular_nxt;
      age_r     <= age_nxt;
    end
  end

  // held words are zero whenever the command is not valid
  assign cmd_valid    = valid_nxt;
  assign linear_bits  = valid_nxt ? linear_nxt  : 32'd0;
  assign angular_bits = valid_nxt ? angular_nxt : 32'd0;

endmodule

// ===== rtl/core/crc_checked_command_deframer_top.sv =====
// Serial command deframer. Each input transaction is one received byte
// (mode 0) or one millisecond tick (mode 1), and each gives exactly one
// result transaction. Frames are sync1, sync2, length, eight payload bytes
// and a little-endian CRC-16 CCITT-FALSE over the first eleven bytes; a
// repeated first sync byte restarts the frame. frame_status reports the
// outcome on the last CRC byte (1 accepted, 2 bad length, 3 bad CRC) and is
// 0 otherwise. A good frame latches two 32-bit little-endian words and sets
// cmd_valid; ticks age it, and once the age exceeds timeout_ms the command
// drops to zero. One transaction is taken per cycle unless a result waits
// on out_ready; the byte-wide CRC update and state step sit between the
// input handshake and the result register. Configuration writes are taken
// at any time with cfg_ready always high; unknown indexes are ignored.
module crc_checked_command_deframer_top import ccd_pkg::*; #(
  parameter int AGE_WIDTH = AGE_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_regs_t  cfg_r;
  logic       out_valid_r;
  out_item_t  out_data_r;
  logic       in_accept;
  logic       byte_en;
  logic       tick_en;
  logic [1:0] status;
  frame_evt_t frame_evt;
  logic       cmd_valid;
  logic [31:0] linear_bits;
  logic [31:0] angular_bits;

  // handshake: take a new transaction whenever the result slot frees up
  assign in_ready  = !out_valid_r || out_ready;
  assign in_accept = in_valid && in_ready;
  assign byte_en   = in_accept && (in_data.mode == MODE_BYTE);
  assign tick_en   = in_accept && (in_data.mode == MODE_TICK);
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.first_sync      <= FIRST_SYNC_RST;
      cfg_r.second_sync     <= SECOND_SYNC_RST;
      cfg_r.expected_length <= EXPECTED_LENGTH_RST;
      cfg_r.timeout_ms      <= TIMEOUT_MS_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FIRST_SYNC:      cfg_r.first_sync      <= cfg_data[7:0];
        REG_SECOND_SYNC:     cfg_r.second_sync     <= cfg_data[7:0];
        REG_EXPECTED_LENGTH: cfg_r.expected_length <= cfg_data[7:0];
        REG_TIMEOUT_MS:      cfg_r.timeout_ms      <= cfg_data;
        default: ;
      endcase
    end
  end

  ccd_deframer u_deframer (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_en   (byte_en),
    .rx_byte   (in_data.rx_byte),
    .cfg       (cfg_r),
    .status    (status),
    .frame_evt (frame_evt)
  );

  ccd_cmd_hold #(
    .AGE_WIDTH (AGE_WIDTH)
  ) u_cmd_hold (
    .clk          (clk),
    .rst_n        (rst_n),
    .tick_en      (tick_en),
    .frame_evt    (frame_evt),
    .timeout_ms   (cfg_r.timeout_ms),
    .cmd_valid    (cmd_valid),
    .linear_bits  (linear_bits),
    .angular_bits (angular_bits)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data_r.cmd_valid    <= cmd_valid;
      out_data_r.linear_bits  <= linear_bits;
      out_data_r.angular_bits <= angular_bits;
      out_data_r.frame_status <= status;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
